// ----- src/icc_pkg.sv -----
// Shared types and constants for the identifier case converter.
// No dependencies; imported by every module of the block.
package icc_pkg;

    // Naming style codes
    localparam logic [3:0] STYLE_SNAKE        = 4'd0;
    localparam logic [3:0] STYLE_KEBAB        = 4'd1;
    localparam logic [3:0] STYLE_FLAT         = 4'd2;
    localparam logic [3:0] STYLE_SCREAM_SNAKE = 4'd3;
    localparam logic [3:0] STYLE_UPPER_FLAT   = 4'd4;
    localparam logic [3:0] STYLE_COBOL        = 4'd5;
    localparam logic [3:0] STYLE_PASCAL       = 4'd6;
    localparam logic [3:0] STYLE_PASCAL_SNAKE = 4'd7;
    localparam logic [3:0] STYLE_TRAIN        = 4'd8;
    localparam logic [3:0] STYLE_CAMEL        = 4'd9;
    localparam logic [3:0] STYLE_CAMEL_SNAKE  = 4'd10;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    // One output word
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       end_out;
    } res_t;

    // Word-boundary tracking state
    typedef struct packed {
        logic inside_word;
        logic prev_was_lower;
        logic word_emitted;
    } trk_t;

    // Decoded outcome of one input byte
    typedef struct packed {
        logic pre_en;     // separator or leading '_' goes out first
        res_t pre;
        logic main_en;    // a converted byte or bare end marker goes out
        res_t main;
        trk_t trk_next;
    } dec_t;

endpackage

// ----- src/icc_decode.sv -----
// Combinational conversion of one byte against the current word state.
// Depends on icc_pkg.
module icc_decode
    import icc_pkg::*;
(
    input  logic [7:0] char_in,
    input  logic       end_in,
    input  logic [3:0] style,
    input  trk_t       trk,
    output dec_t       dec
);

    logic       is_lower;
    logic       is_upper;
    logic       is_digit;
    logic       is_alnum;
    logic       start;
    logic [7:0] sep;
    logic       force_upper;
    logic       cap_start;
    logic [7:0] lower_c;
    logic [7:0] upper_c;
    logic [7:0] conv;

    // Classify the byte
    assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h7A);
    assign is_upper = (char_in >= 8'h41) && (char_in <= 8'h5A);
    assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign is_alnum = is_lower || is_upper || is_digit;
    assign start    = !trk.inside_word || (trk.prev_was_lower && is_upper);

    assign lower_c = is_upper ? (char_in | CASE_BIT) : char_in;
    assign upper_c = is_lower ? (char_in & ~CASE_BIT) : char_in;

    // Pick separator and case rule per style; unknown codes act as flat
    always_comb
    begin
        sep         = CH_NUL;
        force_upper = 1'b0;
        cap_start   = 1'b0;
        unique case (style)
            STYLE_SNAKE:        sep = CH_UNDERSCORE;
            STYLE_KEBAB:        sep = CH_HYPHEN;
            STYLE_FLAT:         sep = CH_NUL;
            STYLE_SCREAM_SNAKE:
            begin
                sep         = CH_UNDERSCORE;
                force_upper = 1'b1;
            end
            STYLE_UPPER_FLAT:   force_upper = 1'b1;
            STYLE_COBOL:
            begin
                sep         = CH_HYPHEN;
                force_upper = 1'b1;
            end
            STYLE_PASCAL:       cap_start = 1'b1;
            STYLE_PASCAL_SNAKE:
            begin
                sep       = CH_UNDERSCORE;
                cap_start = 1'b1;
            end
            STYLE_TRAIN:
            begin
                sep       = CH_HYPHEN;
                cap_start = 1'b1;
            end
            STYLE_CAMEL:        cap_start = trk.word_emitted;
            STYLE_CAMEL_SNAKE:
            begin
                sep       = CH_UNDERSCORE;
                cap_start = trk.word_emitted;
            end
            default:            sep = CH_NUL;
        endcase
    end

    assign conv = (force_upper || (cap_start && start)) ? upper_c : lower_c;

    // Build the outgoing words and the next state
    always_comb
    begin
        dec = '0;
        if (is_alnum)
        begin
            if (start && trk.word_emitted && (sep != CH_NUL))
            begin
                dec.pre_en = 1'b1;
                dec.pre    = '{char_out: sep, char_valid: 1'b1, end_out: 1'b0};
            end
            else if (start && !trk.word_emitted && is_digit)
            begin
                dec.pre_en = 1'b1;
                dec.pre    = '{char_out: CH_UNDERSCORE, char_valid: 1'b1, end_out: 1'b0};
            end
            dec.main_en = 1'b1;
            dec.main    = '{char_out: conv, char_valid: 1'b1, end_out: end_in};
            dec.trk_next = '{inside_word: 1'b1, prev_was_lower: is_lower,
                             word_emitted: 1'b1};
        end
        else
        begin
            dec.main_en  = end_in;
            dec.main     = '{char_out: CH_NUL, char_valid: 1'b0, end_out: end_in};
            dec.trk_next = '{inside_word: 1'b0, prev_was_lower: 1'b0,
                             word_emitted: trk.word_emitted};
        end
        // End marker returns the tracker to its reset values
        if (end_in)
        begin
            dec.trk_next = '0;
        end
    end

endmodule

// ----- src/icc_out_stage.sv -----
// Output register for the master-side stream.
// Depends on icc_pkg.
module icc_out_stage
    import icc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tuser,   // [0] char_valid
    output logic       m_tlast    // end_out
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;

    // Free when empty or when the held word leaves this cycle
    assign ready = !out_valid_reg || m_tready;

    assign out_valid_next = load || (out_valid_reg && !m_tready);

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.char_out;
    assign m_tuser  = out_res_reg.char_valid;
    assign m_tlast  = out_res_reg.end_out;

endmodule

// ----- src/identifier_case_converter_unit.sv -----
// Identifier case converter, top level: input register, word tracker, output stage.
// Depends on icc_pkg, icc_decode and icc_out_stage.
//
// Rewrites an identifier streamed one byte per word into the naming style held
// in the style register (cfg_wen/cfg_wdata, write only while the stream is idle).
// A byte yields one output word, or two when it needs a separator or a leading
// '_'; the single output register sends one byte per cycle while m_tready is
// high. Delimiter bytes produce nothing, except that an end marker on one gives
// a bare word with tuser low. The first output word of a byte is held in the
// input register and then in the output register before it is valid.
module identifier_case_converter_unit
    import icc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [3:0] cfg_wdata,  // target_style
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_in
    input  logic       s_tlast,    // end_in
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] char_out
    output logic       m_tuser,    // [0] char_valid
    output logic       m_tlast     // end_out
);

    logic [3:0] style_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       phase_reg;
    logic       phase_next;
    trk_t       trk_reg;
    trk_t       trk_next;
    dec_t       dec;
    logic       need_pre;
    logic       out_ready;
    logic       load;
    logic       done;
    res_t       res;

    icc_decode u_decode
    (
        .char_in (in_char_reg),
        .end_in  (in_end_reg),
        .style   (style_reg),
        .trk     (trk_reg),
        .dec     (dec)
    );

    // Sequence prefix word then main word
    assign need_pre = dec.pre_en && !phase_reg;
    assign load     = in_valid_reg && (need_pre || dec.main_en) && out_ready;
    assign done     = in_valid_reg && (!dec.main_en || (out_ready && !need_pre));
    assign res      = need_pre ? dec.pre : dec.main;

    assign s_tready      = !in_valid_reg || done;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !done);
    assign phase_next    = done ? 1'b0 : (phase_reg || (load && need_pre));
    assign trk_next      = done ? dec.trk_next : trk_reg;

    // Control state and style register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg    <= STYLE_SNAKE;
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            trk_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                style_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            trk_reg      <= trk_next;
        end
    end

    // Capture incoming word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    icc_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- src/icc_checker.sv -----
// Port-level checks for the identifier case converter.
// Depends on identifier_case_converter_unit; attached by the bind below.
module icc_checker
    import icc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A bare word only closes a string
    a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == CH_NUL))
        else $error("bare word without end or with data");

    // Emitted bytes are letters, digits or separators
    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
            ((m_tdata >= 8'h41) && (m_tdata <= 8'h5A)) ||
            ((m_tdata >= 8'h61) && (m_tdata <= 8'h7A)) ||
            (m_tdata == CH_UNDERSCORE) || (m_tdata == CH_HYPHEN))
        else $error("unexpected output byte");

    // A hyphen separator never closes a string
    a_sep_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && (m_tdata == CH_HYPHEN) |-> !m_tlast)
        else $error("string ended on a hyphen");

endmodule

bind identifier_case_converter_unit icc_checker u_icc_checker (.*);
